// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LJ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define LJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/lj_pkg.sv =====
// ----------------------------------------------------------------------------
// lj_pkg
// Types, constants and helpers for the Lennard-Jones energy block.
// ----------------------------------------------------------------------------
package lj_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = ADDR_W + 1;

    // one quotient bit per step, two steps per cell, 48 live quotient bits
    localparam int DIV_CELLS = 24;
    localparam int S_W       = 35;
    localparam int Q_W       = 48;

    localparam logic [57:0] CUT_SQ    = 58'd26843545600;  // 6.25 in Q.32
    localparam logic [57:0] S_MIN     = 58'd65536;        // below this 1/r^4 overflows
    localparam logic [31:0] TAIL_K    = 32'd2299667184;
    localparam logic signed [62:0] E_MAX = 63'sd140737488355327;
    localparam logic signed [62:0] E_MIN = -63'sd140737488355328;
    localparam logic signed [64:0] T_MAX = 65'sd35184372088831; // (2^47-1)/4

    localparam logic [1:0] CFG_COUNT   = 2'd0;
    localparam logic [1:0] CFG_BOX     = 2'd1;
    localparam logic [1:0] CFG_DENSITY = 2'd2;

    typedef struct packed {
        logic valid;
        logic live;   // pair contributes a term
        logic sat;    // pair term saturated
        logic last;   // end-of-query marker
    } t_pair_flags;

    typedef struct packed {
        t_pair_flags      flags;
        logic [S_W-1:0]   s;
        logic [S_W-1:0]   rem;
        logic [Q_W-1:0]   q;
    } t_div_bus;

    // minimum image, single wrap
    function automatic logic signed [27:0] f_wrap(input logic signed [27:0] d,
                                                  input logic [25:0] box);
        logic signed [29:0] d2;
        logic signed [29:0] b;
        logic signed [29:0] r;
        d2 = 30'(d) <<< 1;
        b  = signed'(30'(box));
        r  = 30'(d);
        if (d2 < -b) begin
            r = 30'(d) + b;
        end else if (d2 > b) begin
            r = 30'(d) - b;
        end
        return r[27:0];
    endfunction

endpackage

// ===== hdl/lj_div_cell.sv =====
// ----------------------------------------------------------------------------
// lj_div_cell
// One cell of the reciprocal row: two restoring steps of all-ones / s.
// ----------------------------------------------------------------------------
module lj_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lj_pkg::t_div_bus i_bus,
    output lj_pkg::t_div_bus o_bus
);

    lj_pkg::t_div_bus r_bus;
    lj_pkg::t_div_bus n_bus;

    logic [lj_pkg::S_W:0]   w_t1;
    logic [lj_pkg::S_W:0]   w_t2;
    logic [lj_pkg::S_W-1:0] w_rem1;
    logic                   w_ge1;
    logic                   w_ge2;

    always_comb begin
        // dividend bits are all ones
        w_t1   = {i_bus.rem, 1'b1};
        w_ge1  = w_t1 >= {1'b0, i_bus.s};
        w_rem1 = w_ge1 ? lj_pkg::S_W'(w_t1 - {1'b0, i_bus.s}) : w_t1[lj_pkg::S_W-1:0];
        w_t2   = {w_rem1, 1'b1};
        w_ge2  = w_t2 >= {1'b0, i_bus.s};
        n_bus  = i_bus;
        n_bus.rem = w_ge2 ? lj_pkg::S_W'(w_t2 - {1'b0, i_bus.s}) : w_t2[lj_pkg::S_W-1:0];
        n_bus.q   = {i_bus.q[lj_pkg::Q_W-3:0], w_ge1, w_ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= '0;
        end else begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== hdl/lj_mulq.sv =====
// ----------------------------------------------------------------------------
// lj_mulq
// Q.32 product floor(a*b/2^32) in two stages, flagging live results >= 2^63.
// ----------------------------------------------------------------------------
module lj_mulq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lj_pkg::t_pair_flags i_flags,
    input  logic [63:0]         i_a,
    input  logic [63:0]         i_b,
    input  logic [63:0]         i_side,
    output lj_pkg::t_pair_flags o_flags,
    output logic [63:0]         o_p,
    output logic [63:0]         o_side
);

    lj_pkg::t_pair_flags r1_flags;
    logic [63:0]         r1_ll;
    logic [63:0]         r1_lh;
    logic [63:0]         r1_hl;
    logic [63:0]         r1_hh;
    logic [63:0]         r1_side;

    lj_pkg::t_pair_flags r2_flags;
    logic [63:0]         r2_p;
    logic [63:0]         r2_side;

    logic [127:0]        w_p;
    logic                w_psat;
    lj_pkg::t_pair_flags w_flags2;

    // partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_flags <= '0;
        end else begin
            r1_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ll   <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
        r1_lh   <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
        r1_hl   <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
        r1_hh   <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
        r1_side <= i_side;
    end

    always_comb begin
        w_p    = 128'(r1_ll) + (128'(r1_lh) << 32) + (128'(r1_hl) << 32)
               + (128'(r1_hh) << 64);
        w_psat = |w_p[127:95];
        w_flags2     = r1_flags;
        w_flags2.sat = r1_flags.sat | (r1_flags.live & w_psat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_flags <= '0;
        end else begin
            r2_flags <= w_flags2;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_p    <= {1'b0, w_p[94:32]};
        r2_side <= r1_side;
    end

    assign o_flags = r2_flags;
    assign o_p     = r2_p;
    assign o_side  = r2_side;

endmodule

// ===== hdl/lennard_jones_particle_energy_top.sv =====
// ----------------------------------------------------------------------------
// lennard_jones_particle_energy_top
// Lennard-Jones energy of a test position against a store of particles.
// ----------------------------------------------------------------------------
// A load transaction writes one position into the store. A query
// transaction walks stored particles 0 .. min(particle_count,1024)-1, one pair
// per cycle through a 35-stage pair pipeline (store read, wrap, square, sum,
// a row of 24 reciprocal cells, three Q.32 multipliers, term); the result is
// offered once the end-of-query marker leaves the term stage. One query is in
// flight at a time; a finished result waits in the output register (with one
// spare slot) while the next transaction is taken. The store has no reset:
// query only written slots.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lennard_jones_particle_energy_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [25:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic [lj_pkg::ADDR_W-1:0]           i_index,
    input  logic signed [26:0]                  i_pos_x,
    input  logic signed [26:0]                  i_pos_y,
    input  logic signed [26:0]                  i_pos_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [47:0]                  o_energy,
    output logic                                o_saturated
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [lj_pkg::CNT_W-1:0] r_cnt;
    logic [25:0]              r_box;
    logic [19:0]              r_dens;
    logic [30:0]              r_dc;
    logic [31:0]              r_mag;
    logic [63:0]              w_tail;

    // query context
    logic [lj_pkg::ADDR_W-1:0] r_qidx;
    logic signed [26:0]        r_px;
    logic signed [26:0]        r_py;
    logic signed [26:0]        r_pz;
    logic [lj_pkg::CNT_W-1:0]  r_j;
    logic [lj_pkg::CNT_W-1:0]  w_cnt_eff;
    logic                      w_in_acc;
    logic                      w_load;
    logic                      w_query;
    logic                      w_more;
    lj_pkg::t_pair_flags       w_issue;

    // store
    logic signed [26:0] mem_x [lj_pkg::MAX_PARTICLES];
    logic signed [26:0] mem_y [lj_pkg::MAX_PARTICLES];
    logic signed [26:0] mem_z [lj_pkg::MAX_PARTICLES];
    logic signed [26:0] r_rd_x;
    logic signed [26:0] r_rd_y;
    logic signed [26:0] r_rd_z;

    // pair pipeline front
    lj_pkg::t_pair_flags r_s1_flags;
    lj_pkg::t_pair_flags r_s2_flags;
    lj_pkg::t_pair_flags r_s3_flags;
    lj_pkg::t_pair_flags w_s_flags;
    logic signed [27:0]  r_dx;
    logic signed [27:0]  r_dy;
    logic signed [27:0]  r_dz;
    logic [55:0]         r_sx;
    logic [55:0]         r_sy;
    logic [55:0]         r_sz;
    logic [27:0]         w_mx;
    logic [27:0]         w_my;
    logic [27:0]         w_mz;
    logic [57:0]         w_s;

    lj_pkg::t_div_bus    r_div_in;
    lj_pkg::t_div_bus    w_div [lj_pkg::DIV_CELLS+1];

    // multipliers
    lj_pkg::t_pair_flags w_a_flags;
    lj_pkg::t_pair_flags w_b_flags;
    lj_pkg::t_pair_flags w_c_flags;
    logic [63:0]         w_inv2;
    logic [63:0]         w_a_p;
    logic [63:0]         w_a_side;
    logic [63:0]         w_b_p;
    logic [63:0]         w_b_side;
    logic [63:0]         w_c_p;
    logic [63:0]         w_c_side;

    // term and accumulation
    logic signed [64:0]  w_d;
    logic signed [64:0]  w_t;
    lj_pkg::t_pair_flags w_t_flags;
    lj_pkg::t_pair_flags r_t_flags;
    logic signed [50:0]  r_term;
    logic signed [61:0]  r_acc;
    logic                r_acc_sat;
    logic                w_fin;
    logic signed [62:0]  w_total;
    logic signed [47:0]  w_energy;
    logic                w_sat_out;

    // output
    logic                r_out_valid;
    logic signed [47:0]  r_energy;
    logic                r_sat;
    logic                r_pend_valid;
    logic signed [47:0]  r_pend_energy;
    logic                r_pend_sat;
    logic                w_out_free;

    // ------------------------------------------------------------------
    // configuration and tail term
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_box  <= 26'd655360;
            r_dens <= 20'd52429;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lj_pkg::CFG_COUNT:   r_cnt  <= i_cfg_data[lj_pkg::CNT_W-1:0];
                lj_pkg::CFG_BOX:     r_box  <= i_cfg_data;
                lj_pkg::CFG_DENSITY: r_dens <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    assign w_tail = 64'(lj_pkg::TAIL_K) * 64'(r_dc) + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        r_dc  <= 31'(r_dens) * 31'(r_cnt);
        r_mag <= w_tail[63:32];
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != ST_IDLE) || r_pend_valid;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_load     = w_in_acc && !i_action;
    assign w_query    = w_in_acc && i_action;

    assign w_cnt_eff = (r_cnt > lj_pkg::CNT_W'(lj_pkg::MAX_PARTICLES))
                     ? lj_pkg::CNT_W'(lj_pkg::MAX_PARTICLES) : r_cnt;
    assign w_more    = r_j < w_cnt_eff;

    always_comb begin
        w_issue       = '0;
        w_issue.valid = (r_state == ST_RUN);
        w_issue.live  = w_more && (r_j[lj_pkg::ADDR_W-1:0] != r_qidx);
        w_issue.last  = !w_more;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_query) n_state = ST_RUN;
            ST_RUN:   if (!w_more) n_state = ST_DRAIN;
            ST_DRAIN: if (w_fin) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (w_query) begin
                r_j <= '0;
            end else if (r_state == ST_RUN && w_more) begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qidx <= i_index;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
        end
    end

    // ------------------------------------------------------------------
    // position store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem_x[i_index] <= i_pos_x;
            mem_y[i_index] <= i_pos_y;
            mem_z[i_index] <= i_pos_z;
        end
        r_rd_x <= mem_x[r_j[lj_pkg::ADDR_W-1:0]];
        r_rd_y <= mem_y[r_j[lj_pkg::ADDR_W-1:0]];
        r_rd_z <= mem_z[r_j[lj_pkg::ADDR_W-1:0]];
    end

    // ------------------------------------------------------------------
    // pair front: wrap, square, sum and cutoff
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_flags <= '0;
            r_s2_flags <= '0;
            r_s3_flags <= '0;
        end else begin
            r_s1_flags <= w_issue;
            r_s2_flags <= r_s1_flags;
            r_s3_flags <= r_s2_flags;
        end
    end

    assign w_mx = r_dx[27] ? 28'(-r_dx) : 28'(r_dx);
    assign w_my = r_dy[27] ? 28'(-r_dy) : 28'(r_dy);
    assign w_mz = r_dz[27] ? 28'(-r_dz) : 28'(r_dz);
    assign w_s  = 58'(r_sx) + 58'(r_sy) + 58'(r_sz);

    always_ff @(posedge i_clk) begin
        r_dx <= lj_pkg::f_wrap(28'(r_px) - 28'(r_rd_x), r_box);
        r_dy <= lj_pkg::f_wrap(28'(r_py) - 28'(r_rd_y), r_box);
        r_dz <= lj_pkg::f_wrap(28'(r_pz) - 28'(r_rd_z), r_box);
        r_sx <= 56'(w_mx) * 56'(w_mx);
        r_sy <= 56'(w_my) * 56'(w_my);
        r_sz <= 56'(w_mz) * 56'(w_mz);
    end

    always_comb begin
        w_s_flags      = r_s3_flags;
        // too close (or coincident): 1/r^4 already overflows
        w_s_flags.sat  = r_s3_flags.live && (w_s < lj_pkg::S_MIN);
        w_s_flags.live = r_s3_flags.live && (w_s < lj_pkg::CUT_SQ)
                         && (w_s >= lj_pkg::S_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_in <= '0;
        end else begin
            r_div_in.flags <= w_s_flags;
            r_div_in.s     <= w_s[lj_pkg::S_W-1:0];
            r_div_in.rem   <= lj_pkg::S_W'(16'hFFFF);
            r_div_in.q     <= '0;
        end
    end

    // ------------------------------------------------------------------
    // reciprocal cell row: inv2 = floor((2^64-1)/s)
    // ------------------------------------------------------------------
    assign w_div[0] = r_div_in;

    for (genvar g = 0; g < lj_pkg::DIV_CELLS; g++) begin : g_div
        lj_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_div[g]),
            .o_bus   (w_div[g+1])
        );
    end

    assign w_inv2 = 64'(w_div[lj_pkg::DIV_CELLS].q);

    // ------------------------------------------------------------------
    // powers: inv4, inv6, inv12
    // ------------------------------------------------------------------
    lj_mulq u_mul_inv4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_div[lj_pkg::DIV_CELLS].flags),
        .i_a     (w_inv2),
        .i_b     (w_inv2),
        .i_side  (w_inv2),
        .o_flags (w_a_flags),
        .o_p     (w_a_p),
        .o_side  (w_a_side)
    );

    lj_mulq u_mul_inv6 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_a_flags),
        .i_a     (w_a_p),
        .i_b     (w_a_side),
        .i_side  (w_a_side),
        .o_flags (w_b_flags),
        .o_p     (w_b_p),
        .o_side  (w_b_side)
    );

    lj_mulq u_mul_inv12 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_b_flags),
        .i_a     (w_b_p),
        .i_b     (w_b_p),
        .i_side  (w_b_p),
        .o_flags (w_c_flags),
        .o_p     (w_c_p),
        .o_side  (w_c_side)
    );

    // ------------------------------------------------------------------
    // pair term and accumulation
    // ------------------------------------------------------------------
    assign w_d = signed'({1'b0, w_c_p}) - signed'({1'b0, w_c_side});
    assign w_t = w_d >>> 16;

    always_comb begin
        w_t_flags     = w_c_flags;
        w_t_flags.sat = w_c_flags.sat || (w_c_flags.live && (w_t > lj_pkg::T_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_flags <= '0;
        end else begin
            r_t_flags <= w_t_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= signed'({w_t[48:0], 2'b00});
    end

    assign w_fin = r_t_flags.valid && r_t_flags.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_acc_sat <= 1'b0;
        end else if (w_query) begin
            r_acc     <= '0;
            r_acc_sat <= 1'b0;
        end else if (r_t_flags.valid) begin
            if (r_t_flags.sat) begin
                r_acc_sat <= 1'b1;
            end else if (r_t_flags.live) begin
                r_acc <= r_acc + 62'(r_term);
            end
        end
    end

    always_comb begin
        w_total   = 63'(r_acc) - signed'(63'(r_mag));
        w_energy  = w_total[47:0];
        w_sat_out = 1'b0;
        if (r_acc_sat) begin
            w_energy  = lj_pkg::E_MAX[47:0];
            w_sat_out = 1'b1;
        end else if (w_total > lj_pkg::E_MAX) begin
            w_energy  = lj_pkg::E_MAX[47:0];
            w_sat_out = 1'b1;
        end else if (w_total < lj_pkg::E_MIN) begin
            w_energy  = lj_pkg::E_MIN[47:0];
            w_sat_out = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // output register with one spare slot
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_pend_valid || w_fin;
            end
            if (w_fin && !w_out_free) begin
                r_pend_valid <= 1'b1;
            end else if (w_out_free) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_pend_valid) begin
                r_energy <= r_pend_energy;
                r_sat    <= r_pend_sat;
            end else begin
                r_energy <= w_energy;
                r_sat    <= w_sat_out;
            end
        end
        if (w_fin) begin
            r_pend_energy <= w_energy;
            r_pend_sat    <= w_sat_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_energy    = r_energy;
    assign o_saturated = r_sat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `LJ_ASSERT_NOW(a_fin_in_drain, i_clk, i_rst_n, w_fin, r_state == ST_DRAIN)
    `LJ_ASSERT_NOW(a_pend_behind_out, i_clk, i_rst_n, r_pend_valid, r_out_valid)
    `LJ_ASSERT_NEXT(a_query_clears, i_clk, i_rst_n, w_query, r_acc == '0 && !r_acc_sat)
    `LJ_ASSERT_NOW(a_no_fin_when_pend, i_clk, i_rst_n, w_fin, !r_pend_valid)

endmodule

// ===== tb/lennard_jones_particle_energy_top_test.sv =====
// ----------------------------------------------------------------------------
// lennard_jones_particle_energy_top_test
// Self-checking bench for the Lennard-Jones energy block: loads the position
// store, runs queries under several box/density/count settings, and checks
// each energy against a bit-exact fixed-point model kept in the bench.
// ----------------------------------------------------------------------------
module lennard_jones_particle_energy_top_test;

    localparam bit ACT_STORE = 1'b0;
    localparam bit ACT_QUERY = 1'b1;

    localparam longint ENERGY_HI = 64'sd140737488355327;
    localparam longint ENERGY_LO = -64'sd140737488355328;
    localparam bit [63:0] CUTOFF_SQ_Q32 = 64'd26843545600;
    localparam bit [63:0] TAIL_COEF = 64'd2299667184;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        bit               action;
        bit [9:0]         index;
        bit signed [26:0] x;
        bit signed [26:0] y;
        bit signed [26:0] z;
    } lj_item_t;

    typedef struct {
        bit signed [47:0] energy;
        bit               sat;
    } energy_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [25:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_action = 1'b0;
    logic [lj_pkg::ADDR_W-1:0] i_index = '0;
    logic signed [26:0] i_pos_x = '0;
    logic signed [26:0] i_pos_y = '0;
    logic signed [26:0] i_pos_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [47:0] o_energy;
    logic o_saturated;

    lennard_jones_particle_energy_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_action(i_action), .i_index(i_index),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_energy(o_energy), .o_saturated(o_saturated)
    );

    always #10 i_clk = ~i_clk;

    // bench copy of the block's registers and position store
    bit [10:0] m_count = 11'd0;
    bit [25:0] m_box = 26'd655360;
    bit [19:0] m_density = 20'd52429;
    bit signed [26:0] sx [1024];
    bit signed [26:0] sy [1024];
    bit signed [26:0] sz [1024];
    bit written [1024];

    lj_item_t pending_items [$];
    energy_t  expected_energy [$];
    lj_item_t cur;

    int errors = 0;
    int n_stores = 0;
    int n_queries = 0;
    int n_checked = 0;
    int n_sat = 0;
    int n_issued = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;

    function automatic longint wrap_image(longint d);
        longint b;
        b = longint'(m_box);
        if (2 * d < -b) d = d + b;
        else if (2 * d > b) d = d - b;
        return d;
    endfunction

    function automatic bit [63:0] sq(longint d);
        longint m;
        m = (d < 0) ? -d : d;
        return m * m;
    endfunction

    // floor(a*b / 2^32), flags results of 2^63 and up
    function automatic bit [63:0] qmul(bit [63:0] a, bit [63:0] b, inout bit ovf);
        bit [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 32;
        if (p[127:63] != 0) begin
            ovf = 1'b1;
            return 64'd0;
        end
        return p[63:0];
    endfunction

    function automatic void predict_energy(input bit [9:0] skip, input bit signed [26:0] px,
                                           input bit signed [26:0] py,
                                           input bit signed [26:0] pz,
                                           output energy_t res);
        int lim;
        longint acc, total, dd, t, dx, dy, dz;
        bit [63:0] s, i2, i4, i6, i12, mag;
        bit ovf, term_sat;
        lim = (m_count > 1024) ? 1024 : m_count;
        acc = 0;
        term_sat = 1'b0;
        for (int j = 0; j < lim; j++) begin
            if (j == skip) continue;
            dx = wrap_image(longint'(px) - longint'(sx[j]));
            dy = wrap_image(longint'(py) - longint'(sy[j]));
            dz = wrap_image(longint'(pz) - longint'(sz[j]));
            s = sq(dx) + sq(dy) + sq(dz);
            if (s >= CUTOFF_SQ_Q32) continue;
            if (s == 0) begin
                term_sat = 1'b1;
                continue;
            end
            ovf = 1'b0;
            i6 = 0;
            i12 = 0;
            i2 = 64'hFFFF_FFFF_FFFF_FFFF / s;
            i4 = qmul(i2, i2, ovf);
            if (!ovf) i6 = qmul(i4, i2, ovf);
            if (!ovf) i12 = qmul(i6, i6, ovf);
            if (ovf) begin
                term_sat = 1'b1;
                continue;
            end
            dd = longint'(i12) - longint'(i6);
            if (dd >= 0) t = dd >>> 16;
            else t = -((-dd + 65535) >>> 16);
            if (4 * t > ENERGY_HI) begin
                term_sat = 1'b1;
                continue;
            end
            acc = acc + 4 * t;
        end
        mag = (TAIL_COEF * 64'(m_density) * 64'(m_count) + 64'h8000_0000) >> 32;
        total = acc - longint'(mag);
        res.sat = 1'b1;
        if (term_sat) total = ENERGY_HI;
        else if (total > ENERGY_HI) total = ENERGY_HI;
        else if (total < ENERGY_LO) total = ENERGY_LO;
        else res.sat = 1'b0;
        res.energy = total[47:0];
    endfunction

    task automatic note_mismatch(string msg);
        errors++;
        if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // driver: bursts of transactions with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        energy_t e;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (cur.action == ACT_STORE) begin
                    sx[cur.index] = cur.x;
                    sy[cur.index] = cur.y;
                    sz[cur.index] = cur.z;
                    n_stores++;
                end else begin
                    predict_energy(cur.index, cur.x, cur.y, cur.z, e);
                    expected_energy.push_back(e);
                    n_queries++;
                end
            end
            if (i_in_valid && o_in_stall) begin
                // payload held
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur = pending_items.pop_front();
                i_action <= cur.action;
                i_index <= cur.index;
                i_pos_x <= cur.x;
                i_pos_y <= cur.y;
                i_pos_z <= cur.z;
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: pattern modes, plus one long hold-off
    int hold_cnt = 0;
    int cyc = 0;
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            cyc++;
            if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= $urandom_range(0, 1);
                    2: i_out_stall <= (cyc % 4 != 0);
                    default: i_out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        energy_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_energy.size() == 0) begin
                note_mismatch("energy result with none expected");
            end else begin
                e = expected_energy.pop_front();
                n_checked++;
                if (e.sat) n_sat++;
                if (o_energy !== e.energy || o_saturated !== e.sat)
                    note_mismatch($sformatf("energy exp %0d sat %0b, got %0d sat %0b",
                                            e.energy, e.sat, o_energy, o_saturated));
            end
        end
    end

    task automatic push_item(bit act, bit [9:0] idx, int x, int y, int z);
        lj_item_t it;
        it.action = act;
        it.index = idx;
        it.x = x;
        it.y = y;
        it.z = z;
        pending_items.push_back(it);
        if (act == ACT_STORE) written[idx] = 1'b1;
        n_issued++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || i_in_valid || expected_energy.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, bit [25:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            lj_pkg::CFG_COUNT:   m_count = value[10:0];
            lj_pkg::CFG_BOX:     m_box = value;
            lj_pkg::CFG_DENSITY: m_density = value[19:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int full_pos();
        return int'($signed(27'($urandom)));
    endfunction

    function automatic int cluster_pos();
        return $urandom_range(0, 6 * 65536) - 3 * 65536;
    endfunction

    function automatic int jitter();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 10) - 5;
            1: return $urandom_range(0, 16000) - 8000;
            default: return $urandom_range(0, 120000) - 60000;
        endcase
    endfunction

    initial begin
        int c, nq, j, a;
        bit [25:0] boxes [5];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tail term only, reset settings
        push_item(ACT_QUERY, 10'd0, 0, 0, 0);
        wait_idle();

        // directed: coincident, overflowing sum, far particle, extremes
        a = 12500;
        write_cfg(lj_pkg::CFG_COUNT, 26'd6);
        write_cfg(lj_pkg::CFG_BOX, 26'd655360);
        write_cfg(lj_pkg::CFG_DENSITY, 26'd52429);
        push_item(ACT_STORE, 10'd0, 0, 0, 0);
        push_item(ACT_STORE, 10'd1, a, 0, 0);
        push_item(ACT_STORE, 10'd2, -a, 0, 0);
        push_item(ACT_STORE, 10'd3, 0, a, 0);
        push_item(ACT_STORE, 10'd4, 0, -a, 0);
        push_item(ACT_STORE, 10'd5, 67108863, 67108863, 67108863);
        push_item(ACT_QUERY, 10'd0, 0, 0, 0);      // four close pairs, sum overflows
        push_item(ACT_QUERY, 10'd1023, 0, 0, 0);   // coincident with slot 0
        push_item(ACT_QUERY, 10'd5, 65536, 0, 0);
        push_item(ACT_QUERY, 10'd2, 0, 0, 300);    // too close to slot 0
        push_item(ACT_QUERY, 10'd0, -67108864, -67108864, -67108864);
        push_item(ACT_QUERY, 10'd0, 67108863, 67108863, 67108860);
        push_item(ACT_QUERY, 10'd0, 163840, 0, 0); // at the cutoff from slot 0, but slot 0 is skipped
        wait_idle();
        write_cfg(lj_pkg::CFG_BOX, 26'd0);
        write_cfg(lj_pkg::CFG_DENSITY, 26'hFFFFF);
        push_item(ACT_QUERY, 10'd0, 655360, 0, 0);
        push_item(ACT_QUERY, 10'd9, -67108864, 67108863, 0);
        wait_idle();
        write_cfg(lj_pkg::CFG_BOX, 26'h3FFFFFF);
        write_cfg(lj_pkg::CFG_DENSITY, 26'd0);
        push_item(ACT_QUERY, 10'd3, 67108863, -67108864, 12345);
        push_item(ACT_QUERY, 10'd0, 98304, 98304, 0);
        wait_idle();

        boxes[0] = 26'd655360;
        boxes[1] = 26'd0;
        boxes[2] = 26'h3FFFFFF;
        while (n_issued < 500) begin
            boxes[3] = $urandom_range(3 * 65536, 12 * 65536);
            boxes[4] = 26'($urandom);
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
            write_cfg(lj_pkg::CFG_COUNT, 26'(c));
            write_cfg(lj_pkg::CFG_BOX, boxes[$urandom_range(0, 4)]);
            write_cfg(lj_pkg::CFG_DENSITY,
                      ($urandom_range(0, 2) == 0) ? 26'($urandom_range(0, 20'hFFFFF))
                                                  : 26'($urandom_range(30000, 80000)));
            for (int k = 0; k < c; k++)
                push_item(ACT_STORE, 10'(k), cluster_pos(), cluster_pos(), cluster_pos());
            nq = $urandom_range(10, 20);
            if (!hold_done && n_issued > 250) begin
                hold_go = 1'b1;
                nq = 30;
            end
            for (int k = 0; k < nq; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 3) == 0)
                        push_item(ACT_STORE, 10'($urandom), full_pos(), full_pos(), full_pos());
                    else
                        push_item(ACT_STORE, 10'($urandom_range(0, c + 4)),
                                  cluster_pos(), cluster_pos(), cluster_pos());
                end
                if ($urandom_range(0, 9) == 0) begin
                    push_item(ACT_QUERY, 10'($urandom), full_pos(), full_pos(), full_pos());
                end else if (c > 0 && $urandom_range(0, 4) != 0) begin
                    j = $urandom_range(0, c - 1);
                    push_item(ACT_QUERY, ($urandom_range(0, 1) == 0) ? 10'(j) : 10'($urandom),
                              sx[j] + jitter(), sy[j] + jitter(), sz[j] + jitter());
                end else begin
                    push_item(ACT_QUERY, 10'($urandom), cluster_pos(), cluster_pos(),
                              cluster_pos());
                end
            end
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        if (expected_energy.size() > 0)
            note_mismatch($sformatf("%0d energies never arrived", expected_energy.size()));
        $display("Covered %0d store and %0d query transactions, %0d energies checked",
                 n_stores, n_queries, n_checked);
        $display("%0d saturated results, %0d mismatches", n_sat, errors);
        if (errors == 0)
            $display("PASS lennard_jones_particle_energy_top");
        else
            $display("FAIL lennard_jones_particle_energy_top");
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL lennard_jones_particle_energy_top");
        $finish;
    end

endmodule

// ===== lennard_jones_particle_energy_top.f =====
+incdir+hdl
hdl/lj_pkg.sv
hdl/lj_div_cell.sv
hdl/lj_mulq.sv
hdl/lennard_jones_particle_energy_top.sv
tb/lennard_jones_particle_energy_top_test.sv
